// ===== rtl/fpfa_pkg.sv =====
package fpfa_pkg;

  localparam int MAX_PARTS_DEF = 128;
  localparam int AMT_W         = 16;
  localparam int SLOT_W        = 7;
  localparam int TOTAL_W       = 23;
  localparam int MODE_W        = 2;
  localparam int STAT_W        = 2;
  localparam int POL_W         = 2;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  localparam logic [POL_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [POL_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [POL_W-1:0] FIT_WORST = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [AMT_W-1:0]  amount;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot;
    logic [AMT_W-1:0]   slot_capacity;
    logic [AMT_W-1:0]   leftover;
    logic [AMT_W-1:0]   request_echo;
    logic [TOTAL_W-1:0] sum_capacity;
    logic [TOTAL_W-1:0] sum_occupied;
    logic [TOTAL_W-1:0] sum_fragment;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic exec;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_end;
  } dp_stat_t;

endpackage

// ===== rtl/fpfa_ctrl.sv =====
module fpfa_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fpfa_pkg::MODE_W-1:0] mode,
  input  fpfa_pkg::dp_stat_t          stat,
  output fpfa_pkg::ctl_cmd_t          cmd,
  output logic                        busy
);

  fpfa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpfa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fpfa_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (mode == fpfa_pkg::MODE_ALLOC) ? fpfa_pkg::ST_SCAN
                                                      : fpfa_pkg::ST_EXEC;
        end
      end
      fpfa_pkg::ST_EXEC:   state_next = fpfa_pkg::ST_IDLE;
      fpfa_pkg::ST_SCAN: begin
        // last read data is evaluated in this cycle when the address hits count
        if (stat.scan_end) begin
          state_next = fpfa_pkg::ST_COMMIT;
        end
      end
      fpfa_pkg::ST_COMMIT: state_next = fpfa_pkg::ST_IDLE;
      default:             state_next = fpfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      fpfa_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      fpfa_pkg::ST_EXEC:   cmd.exec = 1'b1;
      fpfa_pkg::ST_SCAN:   cmd.scan = 1'b1;
      fpfa_pkg::ST_COMMIT: cmd.commit = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

endmodule

// ===== rtl/fpfa_dp.sv =====
module fpfa_dp #(
  parameter int MAX_PARTS = fpfa_pkg::MAX_PARTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fpfa_pkg::item_t              item,
  input  logic                         cfg_we,
  input  logic [fpfa_pkg::POL_W-1:0]   cfg_data,
  input  fpfa_pkg::ctl_cmd_t           cmd,
  output fpfa_pkg::dp_stat_t           stat,
  output fpfa_pkg::result_t            result,
  output logic                         done
);

  localparam int AW    = $clog2(MAX_PARTS);
  localparam int CNT_W = $clog2(MAX_PARTS + 1);

  logic [fpfa_pkg::AMT_W-1:0]   part_size [MAX_PARTS];
  logic [MAX_PARTS-1:0]         part_busy;
  logic [CNT_W-1:0]             part_count;
  logic [fpfa_pkg::TOTAL_W-1:0] cap_total, cap_total_next;
  logic [fpfa_pkg::TOTAL_W-1:0] used_total, used_total_next;
  logic [fpfa_pkg::POL_W-1:0]   fit_policy;

  fpfa_pkg::item_t              cur;
  logic [CNT_W-1:0]             scan_addr;
  logic                         rd_v;
  logic [AW-1:0]                rd_idx;
  logic [fpfa_pkg::AMT_W-1:0]   rd_size;
  logic                         rd_busy;
  logic                         best_v;
  logic [AW-1:0]                best_idx;
  logic [fpfa_pkg::AMT_W-1:0]   best_size;

  logic                         scan_end;
  logic                         full;
  logic                         append_ok;
  logic                         take;
  fpfa_pkg::result_t            result_next;

  assign scan_end      = (scan_addr == part_count);
  assign stat.scan_end = scan_end;
  assign full          = (part_count == CNT_W'(MAX_PARTS));
  assign append_ok     = cmd.exec && (cur.mode == fpfa_pkg::MODE_APPEND) && !full;

  // candidate: free and large enough; best/worst replace only on strict improvement
  always_comb begin
    take = 1'b0;
    if (!rd_busy && (rd_size >= cur.amount)) begin
      if (!best_v) begin
        take = 1'b1;
      end else if (fit_policy == fpfa_pkg::FIT_BEST) begin
        take = rd_size < best_size;
      end else if (fit_policy == fpfa_pkg::FIT_WORST) begin
        take = rd_size > best_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (append_ok) begin
      part_size[part_count[AW-1:0]] <= cur.amount;
    end
    rd_size <= part_size[scan_addr[AW-1:0]];
  end

  always_comb begin
    cap_total_next  = cap_total;
    used_total_next = used_total;
    result_next               = '0;
    result_next.request_echo  = cur.amount;
    if (cmd.exec) begin
      case (cur.mode)
        fpfa_pkg::MODE_APPEND: begin
          if (full) begin
            result_next.status = fpfa_pkg::STAT_FULL;
          end else begin
            result_next.slot          = fpfa_pkg::SLOT_W'(part_count);
            result_next.slot_capacity = cur.amount;
            cap_total_next = cap_total + fpfa_pkg::TOTAL_W'(cur.amount);
          end
        end
        fpfa_pkg::MODE_FREE: used_total_next = '0;
        default:             result_next.status = fpfa_pkg::STAT_OK;
      endcase
    end
    if (cmd.commit) begin
      if (best_v) begin
        result_next.slot          = fpfa_pkg::SLOT_W'(best_idx);
        result_next.slot_capacity = best_size;
        result_next.leftover      = best_size - cur.amount;
        used_total_next = used_total + fpfa_pkg::TOTAL_W'(cur.amount);
      end else begin
        result_next.status = fpfa_pkg::STAT_NOFIT;
      end
    end
    result_next.sum_capacity = cap_total_next;
    result_next.sum_occupied = used_total_next;
    result_next.sum_fragment = cap_total_next - used_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part_busy  <= '0;
      part_count <= '0;
      cap_total  <= '0;
      used_total <= '0;
      fit_policy <= fpfa_pkg::FIT_FIRST;
      scan_addr  <= '0;
      rd_v       <= 1'b0;
      best_v     <= 1'b0;
      done       <= 1'b0;
    end else begin
      done       <= cmd.exec || cmd.commit;
      cap_total  <= cap_total_next;
      used_total <= used_total_next;
      if (cfg_we) begin
        fit_policy <= cfg_data;
      end
      if (append_ok) begin
        part_count <= part_count + 1'b1;
      end
      if (cmd.exec && (cur.mode == fpfa_pkg::MODE_FREE)) begin
        part_busy <= '0;
      end
      if (cmd.commit && best_v) begin
        part_busy[best_idx] <= 1'b1;
      end
      if (cmd.load) begin
        scan_addr <= '0;
        best_v    <= 1'b0;
        rd_v      <= 1'b0;
      end else begin
        rd_v <= cmd.scan && !scan_end;
        if (cmd.scan && !scan_end) begin
          scan_addr <= scan_addr + 1'b1;
        end
        if (rd_v && take) begin
          best_v <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
    end
    rd_idx  <= scan_addr[AW-1:0];
    rd_busy <= part_busy[scan_addr[AW-1:0]];
    if (rd_v && take) begin
      best_idx  <= rd_idx;
      best_size <= rd_size;
    end
    if (cmd.exec || cmd.commit) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/fixed_partition_fit_allocator_top.sv =====
// Fixed-partition allocator with first, best and worst fit.
//
// Command channel: drive item (mode, amount) with start high; the word is
// taken at a rising edge where start is high and busy is low. busy stays
// high until the result is issued. Append, free-all and unused modes pass
// through the EXEC state, then done is registered. An allocate scans the
// partition table one entry per cycle through the size memory read port
// (up to MAX_PARTS entries), then passes COMMIT before done. A new word can
// be accepted in the same cycle that done is high.
// Result channel: result is valid for exactly one cycle with done high;
// the receiver cannot stall, so the result must be taken that cycle.
// Config: cfg_we/cfg_data write fit_policy (0 first, 1 best, 2 worst,
// other codes act as first fit); write only while busy is low and no
// result is pending.
// Reset (rst, synchronous): table empty, all partitions free, totals zero,
// policy first fit. Partition sizes are not cleared; only loaded entries
// are ever evaluated.
module fixed_partition_fit_allocator_top #(
  parameter int MAX_PARTS = fpfa_pkg::MAX_PARTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  fpfa_pkg::item_t            item,
  output logic                       busy,
  input  logic                       cfg_we,
  input  logic [fpfa_pkg::POL_W-1:0] cfg_data,
  output logic                       done,
  output fpfa_pkg::result_t          result
);

  fpfa_pkg::ctl_cmd_t cmd;
  fpfa_pkg::dp_stat_t stat;

  fpfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (item.mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  fpfa_dp #(
    .MAX_PARTS (MAX_PARTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result),
    .done     (done)
  );

endmodule

// ===== rtl/fpfa_chk.sv =====
module fpfa_chk (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input fpfa_pkg::result_t result
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result issued while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_busy_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results on back-to-back cycles");

  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != fpfa_pkg::STAT_OK)) |->
      (result.slot == '0 && result.leftover == '0 && result.slot_capacity == '0))
    else $error("failed word reports a slot");

endmodule

bind fixed_partition_fit_allocator_top fpfa_chk u_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== test/alloc_checker.sv =====
module alloc_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  fpfa_pkg::item_t            item,
  input  logic                       busy,
  input  logic                       cfg_we,
  input  logic [fpfa_pkg::POL_W-1:0] cfg_data,
  input  logic                       done,
  input  fpfa_pkg::result_t          result,
  output int                         errors,
  output int                         outstanding
);
  import fpfa_pkg::*;

  localparam int TABLE_DEPTH = MAX_PARTS_DEF;

  logic [AMT_W-1:0]     size_tab [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] taken;
  int                   loaded_cnt;
  logic [TOTAL_W-1:0]   cap_sum;
  logic [TOTAL_W-1:0]   occ_sum;
  logic [POL_W-1:0]     policy;
  result_t              grants_due[$];
  result_t              want;
  int                   mismatches = 0;

  assign errors = mismatches;

  task automatic note_mismatch(string msg);
    $display("alloc_checker: %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp);
    if (got !== exp) begin
      note_mismatch($sformatf("%s got %0h expected %0h", name, got, exp));
    end
  endtask

  // lowest index wins ties; codes other than best/worst act as first fit
  function automatic int find_fit(logic [AMT_W-1:0] need);
    int pick;
    pick = -1;
    for (int i = 0; i < loaded_cnt; i++) begin
      if (taken[i] || need > size_tab[i]) continue;
      if (pick < 0) begin
        pick = i;
        if (policy != FIT_BEST && policy != FIT_WORST) break;
      end else if (policy == FIT_BEST && size_tab[i] < size_tab[pick]) begin
        pick = i;
      end else if (policy == FIT_WORST && size_tab[i] > size_tab[pick]) begin
        pick = i;
      end
    end
    return pick;
  endfunction

  function automatic result_t place_word(item_t w);
    result_t r;
    int      pick;
    r = '0;
    r.status = STAT_OK;
    r.request_echo = w.amount;
    case (w.mode)
      MODE_APPEND: begin
        if (loaded_cnt >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          size_tab[loaded_cnt] = w.amount;
          taken[loaded_cnt] = 1'b0;
          r.slot = SLOT_W'(loaded_cnt);
          r.slot_capacity = w.amount;
          loaded_cnt++;
          cap_sum = cap_sum + TOTAL_W'(w.amount);
        end
      end
      MODE_ALLOC: begin
        pick = find_fit(w.amount);
        if (pick < 0) begin
          r.status = STAT_NOFIT;
        end else begin
          taken[pick] = 1'b1;
          occ_sum = occ_sum + TOTAL_W'(w.amount);
          r.slot = SLOT_W'(pick);
          r.slot_capacity = size_tab[pick];
          r.leftover = size_tab[pick] - w.amount;
        end
      end
      MODE_FREE: begin
        taken = '0;
        occ_sum = '0;
      end
      default: ;
    endcase
    r.sum_capacity = cap_sum;
    r.sum_occupied = occ_sum;
    r.sum_fragment = cap_sum - occ_sum;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      taken = '0;
      loaded_cnt = 0;
      cap_sum = '0;
      occ_sum = '0;
      policy = FIT_FIRST;
      grants_due.delete();
    end else begin
      if (done) begin
        if (grants_due.size() == 0) begin
          note_mismatch("result word with nothing outstanding");
        end else begin
          want = grants_due.pop_front();
          check_field("status", result.status, want.status);
          check_field("slot", result.slot, want.slot);
          check_field("slot_capacity", result.slot_capacity, want.slot_capacity);
          check_field("leftover", result.leftover, want.leftover);
          check_field("request_echo", result.request_echo, want.request_echo);
          check_field("sum_capacity", result.sum_capacity, want.sum_capacity);
          check_field("sum_occupied", result.sum_occupied, want.sum_occupied);
          check_field("sum_fragment", result.sum_fragment, want.sum_fragment);
        end
      end
      if (cfg_we) policy = cfg_data;
      if (start && !busy) grants_due.push_back(place_word(item));
    end
    outstanding = grants_due.size();
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import fpfa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
  localparam logic [POL_W-1:0]  FIT_SPARE   = 2'd3;
  localparam int SEGMENTS      = 6;
  localparam int SEGMENT_WORDS = 172;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = MAX_PARTS_DEF + 8;

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  item_t             item = '0;
  logic              cfg_we = 1'b0;
  logic [POL_W-1:0]  cfg_data = '0;
  logic              busy;
  logic              done;
  result_t           result;
  int                errors;
  int                outstanding;
  int                cycles = 0;
  int                idle_pct = 0;
  logic [AMT_W-1:0]  loaded_sizes[$];
  item_t             rand_word;
  logic [POL_W-1:0]  seg_policy;

  fixed_partition_fit_allocator_top DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  alloc_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .item        (item),
    .busy        (busy),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .done        (done),
    .result      (result),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // returns at the edge that takes the word
  task automatic issue(logic [MODE_W-1:0] m, logic [AMT_W-1:0] a);
    item_t w;
    w.mode = m;
    w.amount = a;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= w;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    if (m == MODE_APPEND && loaded_sizes.size() < MAX_PARTS_DEF) loaded_sizes.push_back(a);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    forever begin
      @(negedge clk);
      if (outstanding == 0 && !busy) break;
    end
  endtask

  // requests mostly aim at loaded sizes so grants, ties and exact fits show up
  function automatic item_t random_word();
    item_t            w;
    int               k;
    logic [AMT_W-1:0] s;
    k = $urandom_range(99);
    if (k < 20) w.mode = MODE_APPEND;
    else if (k < 92) w.mode = MODE_ALLOC;
    else if (k < 97) w.mode = MODE_FREE;
    else w.mode = MODE_SPARE;
    k = $urandom_range(9);
    if (w.mode == MODE_APPEND) begin
      case (k)
        0: w.amount = '0;
        1: w.amount = '1;
        2, 3: w.amount = AMT_W'(64 << $urandom_range(2));
        4, 5: w.amount = AMT_W'($urandom_range(1023));
        default: w.amount = AMT_W'($urandom);
      endcase
    end else if (loaded_sizes.size() > 0 && k >= 4) begin
      s = loaded_sizes[$urandom_range(loaded_sizes.size() - 1)];
      if (k < 6) w.amount = s;
      else w.amount = AMT_W'($urandom_range(s, 0));
    end else begin
      case (k)
        0: w.amount = '0;
        1: w.amount = '1;
        2: w.amount = AMT_W'($urandom_range(255));
        default: w.amount = AMT_W'($urandom);
      endcase
    end
    return w;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // first fit from reset
    issue(MODE_ALLOC, 16'd0);        // empty table
    issue(MODE_APPEND, 16'd0);
    issue(MODE_APPEND, 16'hFFFF);
    issue(MODE_APPEND, 16'd100);
    issue(MODE_APPEND, 16'd100);
    issue(MODE_APPEND, 16'd50);
    issue(MODE_APPEND, 16'd1);
    issue(MODE_ALLOC, 16'hFFFF);
    issue(MODE_ALLOC, 16'd0);        // zero size still claims a slot
    issue(MODE_ALLOC, 16'd0);
    issue(MODE_ALLOC, 16'd200);      // nothing fits
    issue(MODE_ALLOC, 16'd1);
    issue(MODE_FREE, 16'd0);
    issue(MODE_SPARE, 16'hFFFF);
    issue(MODE_ALLOC, 16'd60);
    issue(MODE_ALLOC, 16'd2);
    issue(MODE_FREE, 16'hFFFF);
    issue(MODE_SPARE, 16'd0);
    issue(MODE_ALLOC, 16'd50);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: seg_policy = FIT_BEST;
        1: seg_policy = FIT_WORST;
        2: seg_policy = FIT_SPARE;
        3: seg_policy = FIT_FIRST;
        4: seg_policy = FIT_WORST;
        default: seg_policy = FIT_BEST;
      endcase
      wait_quiet();
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_data <= seg_policy;
      @(posedge clk);
      cfg_we <= 1'b0;
      idle_pct = (seg < 2) ? 7 : ((seg < 4) ? 56 : 0);
      repeat (SEGMENT_WORDS) begin
        rand_word = random_word();
        issue(rand_word.mode, rand_word.amount);
      end
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fpfa_pkg.sv
rtl/fpfa_ctrl.sv
rtl/fpfa_dp.sv
rtl/fixed_partition_fit_allocator_top.sv
rtl/fpfa_chk.sv
test/alloc_checker.sv
test/tb_top.sv
